[rtl/core/afbs_pkg.sv]
// Shared constants, data types and helper functions of the attractive field speed block.
package afbs_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int GUARD            = 8;
  localparam int TABLE_LEN        = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int DX_W   = 21;
  localparam int SQ_W   = 42;
  localparam int ROOT_W = 21;
  localparam int QUO_W  = 22;
  localparam int REM_W  = 44;
  localparam int XY_W   = 31;
  localparam int Z_W    = 25;

  localparam logic [29:0] KINV_Q30 = 30'd652032874;

  typedef enum logic [2:0] {
    REG_SWITCH_RADIUS  = 3'd0,
    REG_ATTRACT_GAIN   = 3'd1,
    REG_REACHED_RADIUS = 3'd2,
    REG_FORWARD_WEIGHT = 3'd3,
    REG_LATERAL_WEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_data_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
    logic [ROOT_W-1:0] den;
  } div_data_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_data_t;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic signed [Z_W-1:0] atan_val(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:  a = 25'sd2949120;
      1:  a = 25'sd1740967;
      2:  a = 25'sd919879;
      3:  a = 25'sd466945;
      4:  a = 25'sd234379;
      5:  a = 25'sd117304;
      6:  a = 25'sd58666;
      7:  a = 25'sd29335;
      8:  a = 25'sd14668;
      9:  a = 25'sd7334;
      10: a = 25'sd3667;
      11: a = 25'sd1833;
      12: a = 25'sd917;
      13: a = 25'sd458;
      14: a = 25'sd229;
      15: a = 25'sd115;
      16: a = 25'sd57;
      17: a = 25'sd29;
      18: a = 25'sd14;
      19: a = 25'sd7;
      20: a = 25'sd4;
      21: a = 25'sd2;
      22: a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Right shift rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                   input int s);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    logic signed [63:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/core/afbs_sqrt_cell.sv]
// One cell of the square root chain: settles one bit of the root.
module afbs_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                  clk,
  input  logic                  adv,
  input  afbs_pkg::sqrt_data_t  d_in,
  output afbs_pkg::sqrt_data_t  d_out
);
  import afbs_pkg::*;

  localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * K);

  logic [SQ_W-1:0] trial;
  sqrt_data_t      d_next;

  always_comb begin
    trial = d_in.root + BIT;
    if (d_in.rem >= trial) begin
      d_next.rem  = d_in.rem - trial;
      d_next.root = (d_in.root >> 1) + BIT;
    end else begin
      d_next.rem  = d_in.rem;
      d_next.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_out <= d_next;
    end
  end

endmodule

[rtl/core/afbs_div_cell.sv]
// One cell of the restoring divider chain: settles one quotient bit.
module afbs_div_cell #(
  parameter int K = 0
) (
  input  logic                 clk,
  input  logic                 adv,
  input  afbs_pkg::div_data_t  d_in,
  output afbs_pkg::div_data_t  d_out
);
  import afbs_pkg::*;

  logic [REM_W-1:0] sh;
  div_data_t        d_next;

  always_comb begin
    sh     = {{(REM_W-ROOT_W){1'b0}}, d_in.den} << K;
    d_next = d_in;
    if (d_in.rem >= sh) begin
      d_next.rem    = d_in.rem - sh;
      d_next.quo[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_out <= d_next;
    end
  end

endmodule

[rtl/core/afbs_cordic_cell.sv]
// One micro-rotation of the CORDIC chain.
module afbs_cordic_cell #(
  parameter int I = 0
) (
  input  logic                 clk,
  input  logic                 adv,
  input  afbs_pkg::rot_data_t  d_in,
  output afbs_pkg::rot_data_t  d_out
);
  import afbs_pkg::*;

  localparam logic signed [Z_W-1:0] ANG = atan_val(I);

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  rot_data_t              d_next;

  always_comb begin
    xs = d_in.x >>> I;
    ys = d_in.y >>> I;
    if (!d_in.z[Z_W-1]) begin
      d_next.x = d_in.x - ys;
      d_next.y = d_in.y + xs;
      d_next.z = d_in.z - ANG;
    end else begin
      d_next.x = d_in.x + ys;
      d_next.y = d_in.y - xs;
      d_next.z = d_in.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_out <= d_next;
    end
  end

endmodule

[rtl/core/attractive_field_body_speed.sv]
// Top level of the attractive potential field speed block.
// One item is taken per clock cycle while the output is not stalled, and
// each gives exactly one result, in order. The pipeline is built around
// three chains of cells: a 21-cell square root chain for the distance, a
// 22-cell divider chain for the conic force, and the CORDIC chain that
// rotates the force into the robot frame. A stall on the result side
// freezes the whole pipeline, so item_stall follows it while a result is
// waiting. Configuration writes are taken at any time but must only be
// made while no item is in flight.
module attractive_field_body_speed #(
  parameter int CORDIC_STEPS = afbs_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [19:0] robot_x,
  input  logic signed [19:0] robot_y,
  input  logic signed [17:0] heading,
  input  logic signed [19:0] target_x,
  input  logic signed [19:0] target_y,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [19:0] force_x,
  output logic signed [19:0] force_y,
  output logic [22:0]        potential,
  output logic signed [21:0] speed_forward,
  output logic signed [21:0] speed_lateral,
  output logic               reached,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [18:0]        cfg_data
);
  import afbs_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int NSQ    = ROOT_W;
  localparam int NDIV   = QUO_W;
  localparam int LAT    = 2 + NSQ + 2 + NDIV + 1 + NSTEPS + 3;

  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } sq_side_t;

  typedef struct packed {
    logic [22:0]        pot;
    logic signed [19:0] qfx;
    logic signed [19:0] qfy;
    logic               sgnx;
    logic               sgny;
    logic               quad;
    logic               rch;
    logic signed [Z_W-1:0] z;
    logic               flip;
  } dv_side_t;

  typedef struct packed {
    logic signed [19:0] fx;
    logic signed [19:0] fy;
    logic [22:0]        pot;
    logic               rch;
  } rt_side_t;

  // Configuration registers.
  logic [17:0] switch_radius;
  logic [18:0] attract_gain;
  logic [16:0] reached_radius;
  logic [18:0] forward_weight;
  logic [18:0] lateral_weight;
  logic [36:0] gain_sw;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_radius  <= 18'd19661;
      attract_gain   <= 19'd65536;
      reached_radius <= 17'd3277;
      forward_weight <= 19'd78643;
      lateral_weight <= 19'd104858;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SWITCH_RADIUS:  switch_radius  <= cfg_data[17:0];
        REG_ATTRACT_GAIN:   attract_gain   <= cfg_data;
        REG_REACHED_RADIUS: reached_radius <= cfg_data[16:0];
        REG_FORWARD_WEIGHT: forward_weight <= cfg_data;
        REG_LATERAL_WEIGHT: lateral_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gain_sw <= 37'(attract_gain) * 37'(switch_radius);
  end

  // Pipeline control: everything moves together unless a result is held.
  logic           adv;
  logic [LAT-1:0] vld;

  assign item_stall = result_valid && result_stall;
  assign adv        = !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[LAT-2:0], item_valid};
      result_valid <= vld[LAT-1];
    end
  end

  // Stage A: offsets and heading folded into the right half plane.
  logic signed [18:0] nh;
  logic signed [18:0] nw;
  logic signed [18:0] zq;
  logic               flp;
  logic signed [DX_W-1:0] a_dx;
  logic signed [DX_W-1:0] a_dy;
  logic signed [Z_W-1:0]  a_z;
  logic                   a_flip;

  always_comb begin
    nh = -$signed({heading[17], heading});
    if (nh >= 19'sd46080) begin
      nw = nh - 19'sd92160;
    end else if (nh < -19'sd46080) begin
      nw = nh + 19'sd92160;
    end else begin
      nw = nh;
    end
    flp = 1'b0;
    zq  = nw;
    if (nw > 19'sd23040) begin
      zq  = nw - 19'sd46080;
      flp = 1'b1;
    end else if (nw < -19'sd23040) begin
      zq  = nw + 19'sd46080;
      flp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx   <= $signed({target_x[19], target_x}) - $signed({robot_x[19], robot_x});
      a_dy   <= $signed({target_y[19], target_y}) - $signed({robot_y[19], robot_y});
      a_z    <= $signed({zq[16:0], 8'b0});
      a_flip <= flp;
    end
  end

  // Stage B: squared distance.
  logic signed [SQ_W-1:0] sqx;
  logic signed [SQ_W-1:0] sqy;
  logic [SQ_W-1:0]        b_sq;
  sq_side_t               b_sd;

  assign sqx = a_dx * a_dx;
  assign sqy = a_dy * a_dy;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sq      <= $unsigned(sqx) + $unsigned(sqy);
      b_sd.dx   <= a_dx;
      b_sd.dy   <= a_dy;
      b_sd.z    <= a_z;
      b_sd.flip <= a_flip;
    end
  end

  // Square root chain.
  sqrt_data_t sq_d  [0:NSQ];
  sq_side_t   sq_sd [0:NSQ];

  assign sq_d[0].rem  = b_sq;
  assign sq_d[0].root = '0;
  assign sq_sd[0]     = b_sd;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    afbs_sqrt_cell #(.K(NSQ - 1 - j)) u_cell (
      .clk   (clk),
      .adv   (adv),
      .d_in  (sq_d[j]),
      .d_out (sq_d[j+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_sd[j+1] <= sq_sd[j];
      end
    end
  end

  // Stage M1: branch decision and partial products.
  logic [ROOT_W-1:0] sigma;
  logic              quad_c;
  logic              rch_c;
  logic [19:0]       adx;
  logic [19:0]       ady;
  logic signed [DX_W-1:0] sdx;
  logic signed [DX_W-1:0] sdy;

  assign sigma  = sq_d[NSQ].root[ROOT_W-1:0];
  assign quad_c = sigma <= ROOT_W'(switch_radius);
  assign rch_c  = sigma <= ROOT_W'(reached_radius);
  assign sdx    = sq_sd[NSQ].dx;
  assign sdy    = sq_sd[NSQ].dy;
  assign adx    = sdx[DX_W-1] ? 20'(-sdx) : 20'(sdx);
  assign ady    = sdy[DX_W-1] ? 20'(-sdy) : 20'(sdy);

  logic [38:0]        m1_plo_x;
  logic [38:0]        m1_plo_y;
  logic [37:0]        m1_phi_x;
  logic [37:0]        m1_phi_y;
  logic signed [40:0] m1_qpx;
  logic signed [40:0] m1_qpy;
  logic [39:0]        m1_pa;
  logic [21:0]        m1_pb;
  logic [ROOT_W-1:0]  m1_sigma;
  logic               m1_sgnx;
  logic               m1_sgny;
  logic               m1_quad;
  logic               m1_rch;
  logic signed [Z_W-1:0] m1_z;
  logic               m1_flip;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_plo_x <= 39'(gain_sw[18:0]) * 39'(adx);
      m1_plo_y <= 39'(gain_sw[18:0]) * 39'(ady);
      m1_phi_x <= 38'(gain_sw[36:19]) * 38'(adx);
      m1_phi_y <= 38'(gain_sw[36:19]) * 38'(ady);
      m1_qpx   <= $signed({1'b0, attract_gain}) * sdx;
      m1_qpy   <= $signed({1'b0, attract_gain}) * sdy;
      m1_pa    <= quad_c ? 40'(attract_gain) * 40'(sigma) : 40'(gain_sw);
      m1_pb    <= quad_c ? 22'(sigma) : {sigma, 1'b0} - 22'(switch_radius);
      m1_sigma <= sigma;
      m1_sgnx  <= sdx[DX_W-1];
      m1_sgny  <= sdy[DX_W-1];
      m1_quad  <= quad_c;
      m1_rch   <= rch_c || (sigma == '0);
      m1_z     <= sq_sd[NSQ].z;
      m1_flip  <= sq_sd[NSQ].flip;
    end
  end

  // Stage M2: dividends, quadratic force, potential partial products.
  logic [57:0] numx;
  logic [57:0] numy;

  assign numx = (58'(m1_phi_x) << 19) + 58'(m1_plo_x) + (58'(m1_sigma) << (FRAC_BITS - 1));
  assign numy = (58'(m1_phi_y) << 19) + 58'(m1_plo_y) + (58'(m1_sigma) << (FRAC_BITS - 1));

  logic [SQ_W-1:0]    m2_nx;
  logic [SQ_W-1:0]    m2_ny;
  logic signed [19:0] m2_qfx;
  logic signed [19:0] m2_qfy;
  logic [41:0]        m2_plo;
  logic [41:0]        m2_phi;
  logic [ROOT_W-1:0]  m2_sigma;
  logic               m2_sgnx;
  logic               m2_sgny;
  logic               m2_quad;
  logic               m2_rch;
  logic signed [Z_W-1:0] m2_z;
  logic               m2_flip;
  logic signed [63:0] qfx_w;
  logic signed [63:0] qfy_w;

  assign qfx_w = sat64(shr_round(64'(m1_qpx), FRAC_BITS), -64'sd524288, 64'sd524287);
  assign qfy_w = sat64(shr_round(64'(m1_qpy), FRAC_BITS), -64'sd524288, 64'sd524287);

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_nx    <= numx[57:FRAC_BITS];
      m2_ny    <= numy[57:FRAC_BITS];
      m2_qfx   <= qfx_w[19:0];
      m2_qfy   <= qfy_w[19:0];
      m2_plo   <= 42'(m1_pa[19:0]) * 42'(m1_pb);
      m2_phi   <= 42'(m1_pa[39:20]) * 42'(m1_pb);
      m2_sigma <= m1_sigma;
      m2_sgnx  <= m1_sgnx;
      m2_sgny  <= m1_sgny;
      m2_quad  <= m1_quad;
      m2_rch   <= m1_rch;
      m2_z     <= m1_z;
      m2_flip  <= m1_flip;
    end
  end

  // Potential finished on entry to the divider chain.
  logic [63:0] pot_p;
  logic [63:0] pot_r;

  assign pot_p = (64'(m2_phi) << 20) + 64'(m2_plo);
  assign pot_r = (pot_p + (64'd1 << (2 * FRAC_BITS))) >> (2 * FRAC_BITS + 1);

  // Divider chains for the conic force components.
  div_data_t dvx_d [0:NDIV];
  div_data_t dvy_d [0:NDIV];
  dv_side_t  dv_sd [0:NDIV];

  assign dvx_d[0].rem = REM_W'(m2_nx);
  assign dvx_d[0].quo = '0;
  assign dvx_d[0].den = m2_sigma;
  assign dvy_d[0].rem = REM_W'(m2_ny);
  assign dvy_d[0].quo = '0;
  assign dvy_d[0].den = m2_sigma;

  assign dv_sd[0].pot  = (pot_r > 64'd8388607) ? 23'd8388607 : pot_r[22:0];
  assign dv_sd[0].qfx  = m2_qfx;
  assign dv_sd[0].qfy  = m2_qfy;
  assign dv_sd[0].sgnx = m2_sgnx;
  assign dv_sd[0].sgny = m2_sgny;
  assign dv_sd[0].quad = m2_quad;
  assign dv_sd[0].rch  = m2_rch;
  assign dv_sd[0].z    = m2_z;
  assign dv_sd[0].flip = m2_flip;

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    afbs_div_cell #(.K(NDIV - 1 - j)) u_cell_x (
      .clk   (clk),
      .adv   (adv),
      .d_in  (dvx_d[j]),
      .d_out (dvx_d[j+1])
    );
    afbs_div_cell #(.K(NDIV - 1 - j)) u_cell_y (
      .clk   (clk),
      .adv   (adv),
      .d_in  (dvy_d[j]),
      .d_out (dvy_d[j+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_sd[j+1] <= dv_sd[j];
      end
    end
  end

  // Stage F: select and saturate the force, load the rotator.
  dv_side_t           fsd;
  logic [QUO_W-1:0]   qx;
  logic [QUO_W-1:0]   qy;
  logic signed [19:0] cfx;
  logic signed [19:0] cfy;
  logic signed [19:0] fx_c;
  logic signed [19:0] fy_c;
  logic signed [XY_W-1:0] xe;
  logic signed [XY_W-1:0] ye;

  assign fsd = dv_sd[NDIV];
  assign qx  = dvx_d[NDIV].quo;
  assign qy  = dvy_d[NDIV].quo;

  always_comb begin
    if (fsd.sgnx) begin
      cfx = (qx > 22'd524288) ? -20'sd524288 : 20'(-$signed(qx));
    end else begin
      cfx = (qx > 22'd524287) ? 20'sd524287 : $signed(qx[19:0]);
    end
    if (fsd.sgny) begin
      cfy = (qy > 22'd524288) ? -20'sd524288 : 20'(-$signed(qy));
    end else begin
      cfy = (qy > 22'd524287) ? 20'sd524287 : $signed(qy[19:0]);
    end
    fx_c = fsd.quad ? fsd.qfx : cfx;
    fy_c = fsd.quad ? fsd.qfy : cfy;
    xe   = XY_W'(fx_c) <<< GUARD;
    ye   = XY_W'(fy_c) <<< GUARD;
  end

  rot_data_t rt_d  [0:NSTEPS];
  rt_side_t  rt_sd [0:NSTEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_d[0].x      <= fsd.flip ? -xe : xe;
      rt_d[0].y      <= fsd.flip ? -ye : ye;
      rt_d[0].z      <= fsd.z;
      rt_sd[0].fx    <= fx_c;
      rt_sd[0].fy    <= fy_c;
      rt_sd[0].pot   <= fsd.pot;
      rt_sd[0].rch   <= fsd.rch;
    end
  end

  for (genvar i = 0; i < NSTEPS; i++) begin : g_rot
    afbs_cordic_cell #(.I(i)) u_cell (
      .clk   (clk),
      .adv   (adv),
      .d_in  (rt_d[i]),
      .d_out (rt_d[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        rt_sd[i+1] <= rt_sd[i];
      end
    end
  end

  // Gain correction, axis weighting and output register.
  logic signed [61:0] k1_px;
  logic signed [61:0] k1_py;
  logic signed [29:0] k2_x;
  logic signed [29:0] k2_y;
  logic signed [49:0] k3_f;
  logic signed [49:0] k3_l;
  rt_side_t           k1_sd;
  rt_side_t           k2_sd;
  rt_side_t           k3_sd;
  logic signed [63:0] k2_xw;
  logic signed [63:0] k2_yw;
  logic signed [63:0] vf_w;
  logic signed [63:0] vl_w;

  assign k2_xw = shr_round(64'(k1_px), 30);
  assign k2_yw = shr_round(64'(k1_py), 30);
  assign vf_w  = sat64(shr_round(64'(k3_f), FRAC_BITS + GUARD),
                       -64'sd2097152, 64'sd2097151);
  assign vl_w  = sat64(shr_round(64'(k3_l), FRAC_BITS + GUARD),
                       -64'sd2097152, 64'sd2097151);

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_px <= rt_d[NSTEPS].x * $signed({1'b0, KINV_Q30});
      k1_py <= rt_d[NSTEPS].y * $signed({1'b0, KINV_Q30});
      k1_sd <= rt_sd[NSTEPS];
      k2_x  <= k2_xw[29:0];
      k2_y  <= k2_yw[29:0];
      k2_sd <= k1_sd;
      k3_f  <= k2_x * $signed({1'b0, forward_weight});
      k3_l  <= k2_y * $signed({1'b0, lateral_weight});
      k3_sd <= k2_sd;
      force_x       <= k3_sd.rch ? '0 : k3_sd.fx;
      force_y       <= k3_sd.rch ? '0 : k3_sd.fy;
      potential     <= k3_sd.pot;
      speed_forward <= k3_sd.rch ? '0 : vf_w[21:0];
      speed_lateral <= k3_sd.rch ? '0 : vl_w[21:0];
      reached       <= k3_sd.rch;
    end
  end

endmodule
